// ===== src/fircf_pkg.sv =====
package fircf_pkg;

    // item kinds carried on the input tuser
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int VALUE_W = 16;
    localparam int COEF_W  = 16;
    localparam int TAPS_W  = 7;
    localparam int OUT_W   = 40;
    localparam int IN_TDATA_W = 24;

    localparam int DEF_MAX_TAPS    = 64;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd64;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                      load;
        logic [IDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0] value;
        logic                      shift;
        logic                      clear;
    } t_cell_ctl;

endpackage

// ===== src/fircf_cell.sv =====
module fircf_cell #(
    parameter int IDX   = 0,
    parameter int SW    = 16,
    parameter int ACC_W = 38
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fircf_pkg::t_cell_ctl    i_ctl,
    input  logic                    i_tap_en,
    input  logic signed [SW-1:0]    i_x,
    output logic signed [SW-1:0]    o_x,
    input  logic signed [ACC_W-1:0] i_sum,
    input  logic                    i_tok,
    output logic signed [ACC_W-1:0] o_sum,
    output logic                    o_tok
);

    localparam int  PW       = fircf_pkg::COEF_W + SW;
    localparam bit  IN_RANGE = (IDX < (2 ** fircf_pkg::IDX_W));

    logic signed [fircf_pkg::COEF_W-1:0] r_coef;
    logic signed [SW-1:0]                r_x;
    logic signed [PW-1:0]                r_prod;
    logic signed [ACC_W-1:0]             r_sum;
    logic                                r_tok;
    logic signed [PW-1:0]                w_prod;
    logic                                w_we;

    assign w_we   = IN_RANGE && i_ctl.load &&
                    (i_ctl.idx == fircf_pkg::IDX_W'(IDX));
    assign w_prod = r_coef * r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
            r_x    <= '0;
            r_tok  <= 1'b0;
        end else begin
            if (w_we) begin
                r_coef <= i_ctl.value;
            end
            if (i_ctl.clear) begin
                r_x <= '0;
            end else if (i_ctl.shift) begin
                r_x <= i_x;
            end
            r_tok <= i_tok;
        end
    end

    // product then running sum, one cell per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_tap_en ? w_prod : '0;
        r_sum  <= i_sum + ACC_W'(r_prod);
    end

    assign o_x   = r_x;
    assign o_sum = r_sum;
    assign o_tok = r_tok;

endmodule

// ===== src/fir_convolution_filter.sv =====
// Causal FIR filter, y[n] = sum over k < tap_count of coef[k] * x[n-k], with
// zero history at the start of a sequence. Items on the slave side carry a
// kind in tuser: load coefficient (coef_index, Q1.15 value), filter sample,
// or clear history. Loads and clears may follow one another back to back. A
// sample is shifted into a row of MAX_TAPS cells, each holding one coefficient
// and one history sample; a token and a running sum then walk the row, one
// cell per clock, and the sample's 40-bit result (full precision, saturated
// only where the sum is wider than 40 bits) enters the output register, or a
// hold register while the output is full. No new item is taken until the
// result reaches the output register, which lets the next item in while a
// result still waits on the master side. The user writes tap_count (reset 64,
// values above MAX_TAPS act as MAX_TAPS) through i_cfg_we only while the
// block is idle; the block does not enforce this.
module fir_convolution_filter #(
    parameter int MAX_TAPS    = fircf_pkg::DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = fircf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fircf_pkg::TAPS_W-1:0]         i_cfg_data,   // tap_count
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [fircf_pkg::IN_TDATA_W-1:0]     s_axis_tdata, // coef_index, value, pad
    input  logic [fircf_pkg::OP_W-1:0]           s_axis_tuser, // op
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [fircf_pkg::OUT_W-1:0]          m_axis_tdata  // filtered
);

    // sample width seen by the history
    localparam int SW    = (SAMPLE_BITS < fircf_pkg::VALUE_W) ? SAMPLE_BITS
                                                              : fircf_pkg::VALUE_W;
    localparam int PW    = fircf_pkg::COEF_W + SW;
    localparam int ACC_W = PW + $clog2(MAX_TAPS) + 1;
    localparam int OUT_W = fircf_pkg::OUT_W;

    // input item fields
    logic [fircf_pkg::IDX_W-1:0]          w_idx;
    logic signed [fircf_pkg::VALUE_W-1:0] w_value;
    logic signed [SW-1:0]                 w_sample;
    logic                                 w_acc;
    fircf_pkg::t_cell_ctl                 w_ctl;

    // control
    logic [fircf_pkg::TAPS_W-1:0] r_tap_count;
    logic                         r_busy;
    logic                         r_go1;
    logic                         r_go2;
    logic                         r_hold_v;
    logic signed [OUT_W-1:0]      r_hold;
    logic                         r_out_v;
    logic signed [OUT_W-1:0]      r_out;

    // cell row
    logic signed [SW-1:0]    w_x   [MAX_TAPS];
    logic signed [ACC_W-1:0] w_sum [MAX_TAPS];
    logic                    w_tok [MAX_TAPS];
    logic [MAX_TAPS-1:0]     w_tap_en;
    logic signed [OUT_W-1:0] w_sat;
    logic                    w_end;
    logic                    w_out_free;

    assign w_idx    = s_axis_tdata[fircf_pkg::IDX_W-1:0];
    assign w_value  = s_axis_tdata[fircf_pkg::IDX_W +: fircf_pkg::VALUE_W];
    assign w_sample = w_value[SW-1:0];

    assign s_axis_tready = !r_busy;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign w_ctl.load  = w_acc && (s_axis_tuser == fircf_pkg::OP_LOAD);
    assign w_ctl.idx   = w_idx;
    assign w_ctl.value = w_value;
    assign w_ctl.shift = w_acc && (s_axis_tuser == fircf_pkg::OP_SAMPLE);
    assign w_ctl.clear = w_acc && (s_axis_tuser == fircf_pkg::OP_CLEAR);

    // row of taps: history shifts toward higher k, sum walks with the token
    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++) begin : g_cell
            // cells past tap_count contribute nothing
            assign w_tap_en[k] = (32'(k) < 32'(r_tap_count));
            if (k == 0) begin : g_head
                fircf_cell #(
                    .IDX   (k),
                    .SW    (SW),
                    .ACC_W (ACC_W)
                ) u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_ctl    (w_ctl),
                    .i_tap_en (w_tap_en[k]),
                    .i_x      (w_sample),
                    .o_x      (w_x[k]),
                    .i_sum    ('0),
                    .i_tok    (r_go2),
                    .o_sum    (w_sum[k]),
                    .o_tok    (w_tok[k])
                );
            end else begin : g_body
                fircf_cell #(
                    .IDX   (k),
                    .SW    (SW),
                    .ACC_W (ACC_W)
                ) u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_ctl    (w_ctl),
                    .i_tap_en (w_tap_en[k]),
                    .i_x      (w_x[k-1]),
                    .o_x      (w_x[k]),
                    .i_sum    (w_sum[k-1]),
                    .i_tok    (w_tok[k-1]),
                    .o_sum    (w_sum[k]),
                    .o_tok    (w_tok[k])
                );
            end
        end
    endgenerate

    // saturate, or sign-extend, the row's sum to the 40-bit result
    generate
        if (ACC_W > OUT_W) begin : g_sat
            localparam logic signed [ACC_W-1:0] SAT_HI =
                ACC_W'({1'b0, {(OUT_W-1){1'b1}}});
            localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
            always_comb begin
                if (w_sum[MAX_TAPS-1] > SAT_HI) begin
                    w_sat = {1'b0, {(OUT_W-1){1'b1}}};
                end else if (w_sum[MAX_TAPS-1] < SAT_LO) begin
                    w_sat = {1'b1, {(OUT_W-1){1'b0}}};
                end else begin
                    w_sat = w_sum[MAX_TAPS-1][OUT_W-1:0];
                end
            end
        end else begin : g_ext
            assign w_sat = OUT_W'(w_sum[MAX_TAPS-1]);
        end
    endgenerate

    assign w_end      = w_tok[MAX_TAPS-1];
    assign w_out_free = !r_out_v || m_axis_tready;

    // tap count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= fircf_pkg::TAPS_RESET;
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_data;
        end
    end

    // sample in flight, token launch, output and hold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_go1    <= 1'b0;
            r_go2    <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            // products are registered after the shift, then the token starts
            r_go1 <= w_ctl.shift;
            r_go2 <= r_go1;
            if (w_ctl.shift) begin
                r_busy <= 1'b1;
            end
            if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            if (w_end) begin
                if (w_out_free) begin
                    r_out_v <= 1'b1;
                    r_busy  <= 1'b0;
                end else begin
                    r_hold_v <= 1'b1;
                end
            end else if (r_hold_v && w_out_free) begin
                r_out_v  <= 1'b1;
                r_hold_v <= 1'b0;
                r_busy   <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_end && !w_out_free) begin
            r_hold <= w_sat;
        end
        if (w_end && w_out_free) begin
            r_out <= w_sat;
        end else if (r_hold_v && w_out_free) begin
            r_out <= r_hold;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;

endmodule

// ===== src/fircf_checker.sv =====
module fircf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [fircf_pkg::OP_W-1:0]       s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [fircf_pkg::OUT_W-1:0]      m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a sample occupies the cell row
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == fircf_pkg::OP_SAMPLE)
        |=> !s_axis_tready)
        else $error("item taken while a sample is in the row");

    // loads, clears and unused kinds do not block the input
    a_ctrl_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != fircf_pkg::OP_SAMPLE)
        |=> s_axis_tready)
        else $error("non-sample item stalled the input");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output or busy state survived reset");

endmodule

bind fir_convolution_filter fircf_checker u_fircf_checker (.*);
